>>> hw/rtl/cfpr_pkg.sv
// Shared types, constants and a glyph lookup function for the clock face pixel renderer.
package cfpr_pkg;

  localparam int unsigned PanelSide = 16;
  localparam int unsigned GlyphSide = 7;
  localparam int unsigned FarCell   = 9;
  localparam int unsigned BarRow    = 7;

  localparam logic [7:0]  WAIT_SHADE   = 8'd35;
  localparam logic [5:0]  SEC_MAX      = 6'd59;
  localparam logic [19:0] US_MAX       = 20'd999999;
  localparam logic [25:0] US_PER_SEC   = 26'd1000000;
  localparam logic [25:0] US_PER_COL   = 26'd3750000;
  // US_PER_COL = 16 * COL_DIV; quotient estimate uses floor(2^32 / COL_DIV)
  localparam logic [25:0] COL_DIV      = 26'd234375;
  localparam logic [40:0] COL_RECIP    = 41'd18325;
  // floor(x / 100) == (x * 5243) >> 19 for x up to 25500
  localparam logic [28:0] PCT_RECIP    = 29'd5243;
  localparam logic [6:0]  PCT_MAX      = 7'd100;

  // register indexes
  localparam logic [1:0] REG_MIN_PCT = 2'd0;
  localparam logic [1:0] REG_BAR_PCT = 2'd1;
  localparam logic [1:0] REG_TWELVE  = 2'd2;
  localparam logic [1:0] REG_FULL    = 2'd3;

  typedef enum logic [2:0] {
    KIND_DARK,
    KIND_WAIT,
    KIND_BAR,
    KIND_HOUR,
    KIND_MIN
  } kind_e;

  typedef enum logic [1:0] {
    BAR_NONE,
    BAR_FULL,
    BAR_PART
  } bcls_e;

  // live settings handed from the register block to the datapath
  typedef struct packed {
    logic [7:0] full;
    logic [7:0] min_level;
    logic [7:0] bar_level;
    logic       twelve;
  } cfg_t;

  typedef struct packed {
    logic [5:0] stage_v;
  } stat_t;

  localparam logic [6:0] GLYPH_ROM [10][7] = '{
    '{7'h3E, 7'h63, 7'h63, 7'h63, 7'h63, 7'h63, 7'h3E},
    '{7'h18, 7'h38, 7'h18, 7'h18, 7'h18, 7'h18, 7'h3E},
    '{7'h3E, 7'h63, 7'h03, 7'h0E, 7'h38, 7'h60, 7'h7F},
    '{7'h3E, 7'h63, 7'h03, 7'h1E, 7'h03, 7'h63, 7'h3E},
    '{7'h0E, 7'h1E, 7'h36, 7'h66, 7'h7F, 7'h06, 7'h06},
    '{7'h7F, 7'h60, 7'h7E, 7'h03, 7'h03, 7'h63, 7'h3E},
    '{7'h1E, 7'h30, 7'h60, 7'h7E, 7'h63, 7'h63, 7'h3E},
    '{7'h7F, 7'h06, 7'h0C, 7'h18, 7'h18, 7'h18, 7'h18},
    '{7'h3E, 7'h63, 7'h63, 7'h3E, 7'h63, 7'h63, 7'h3E},
    '{7'h3E, 7'h63, 7'h63, 7'h3F, 7'h03, 7'h03, 7'h3E}
  };

  function automatic logic glyph_bit(input logic [3:0] digit, input logic [2:0] r,
                                     input logic [2:0] c);
    logic [6:0] bits;
    logic       lit;
    lit = 1'b0;
    if (digit <= 4'd9 && r <= 3'd6 && c <= 3'd6) begin
      bits = GLYPH_ROM[digit][r];
      lit  = bits[3'd6 - c];
    end
    return lit;
  endfunction

endpackage

>>> hw/rtl/cfpr_cfg.sv
// Configuration registers with APB access and pre-scaled brightness levels.
module cfpr_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfpr_pkg::cfg_t     cfg_o
);
  import cfpr_pkg::*;

  logic [6:0]  min_pct_q, bar_pct_q;
  logic        twelve_q;
  logic [7:0]  full_q;
  logic [14:0] min_prod_q, bar_prod_q;
  logic [7:0]  min_level_q, bar_level_q;
  logic [6:0]  min_sat, bar_sat;
  logic [28:0] min_scaled, bar_scaled;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pct_q <= 7'd70;
      bar_pct_q <= 7'd45;
      twelve_q  <= 1'b0;
      full_q    <= 8'd255;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_MIN_PCT: min_pct_q <= pwdata[6:0];
        REG_BAR_PCT: bar_pct_q <= pwdata[6:0];
        REG_TWELVE:  twelve_q  <= pwdata[0];
        REG_FULL:    full_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MIN_PCT: prdata = {25'd0, min_pct_q};
      REG_BAR_PCT: prdata = {25'd0, bar_pct_q};
      REG_TWELVE:  prdata = {31'd0, twelve_q};
      REG_FULL:    prdata = {24'd0, full_q};
      default:     prdata = 32'd0;
    endcase
  end

  // percent saturates at 100
  assign min_sat    = (min_pct_q > PCT_MAX) ? PCT_MAX : min_pct_q;
  assign bar_sat    = (bar_pct_q > PCT_MAX) ? PCT_MAX : bar_pct_q;
  assign min_scaled = 29'(min_prod_q) * PCT_RECIP;
  assign bar_scaled = 29'(bar_prod_q) * PCT_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_prod_q  <= 15'd0;
      bar_prod_q  <= 15'd0;
      min_level_q <= 8'd0;
      bar_level_q <= 8'd0;
    end else begin
      min_prod_q  <= 15'(full_q) * 15'(min_sat);
      bar_prod_q  <= 15'(full_q) * 15'(bar_sat);
      min_level_q <= min_scaled[26:19];
      bar_level_q <= bar_scaled[26:19];
    end
  end

  assign cfg_o = '{full: full_q, min_level: min_level_q, bar_level: bar_level_q,
                   twelve: twelve_q};

endmodule

>>> hw/rtl/cfpr_pipe.sv
// Six-stage pixel datapath: decode and font lookup, bar compare, scale, divide, output.
module cfpr_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfpr_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         column_i,
  input  logic [3:0]         row_i,
  input  logic               time_valid_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  logic [19:0]        microsecond_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         pixel_shade_o,
  output cfpr_pkg::stat_t    stat_o
);
  import cfpr_pkg::*;

  logic [5:0] v_q;
  logic [5:0] en;

  // stage 1: captured fields
  logic [3:0]  col1_q, row1_q;
  logic        tv1_q;
  logic [4:0]  hr1_q;
  logic [5:0]  mn1_q, sec1_q;
  logic [19:0] us1_q;
  // stage 2
  kind_e       kind2_q;
  logic [25:0] t2_q, lo2_q;
  // stage 3
  kind_e       kind3_q;
  bcls_e       cls3_q;
  logic [21:0] diff3_q;
  // stage 4
  kind_e       kind4_q;
  bcls_e       cls4_q;
  logic [29:0] prod4_q;
  // stage 5
  kind_e       kind5_q;
  bcls_e       cls5_q;
  logic [25:0] num5_q;
  logic [7:0]  q05_q;
  // stage 6 (output)
  logic [7:0]  shade6_q;

  // each stage moves when empty or when the one after it moves
  always_comb begin
    en[5] = !v_q[5] || out_ready_i;
    for (int k = 4; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      col1_q <= column_i;
      row1_q <= row_i;
      tv1_q  <= time_valid_i;
      hr1_q  <= hour_i;
      mn1_q  <= minute_i;
      sec1_q <= second_i;
      us1_q  <= microsecond_i;
    end
  end

  // stage 2 logic: region, digit choice, font bit, time and column origin
  kind_e       kind2_d;
  logic [25:0] t2_d, lo2_d;
  always_comb begin
    logic        lower, right, wait_row, wait_col, lit;
    logic [4:0]  hr12;
    logic [5:0]  value;
    logic [13:0] tens_prod;
    logic [3:0]  tens, ones, digit;
    logic [2:0]  gr, gc;
    logic [5:0]  sec_c;
    logic [19:0] us_c;

    lower    = row1_q >= 4'(FarCell);
    right    = col1_q >= 4'(FarCell);
    wait_row = (row1_q == 4'd3) || (row1_q == 4'd12);
    wait_col = (col1_q >= 4'd1 && col1_q <= 4'd5) || (col1_q >= 4'd10 && col1_q <= 4'd14);

    // hour mod 12, zero shown as twelve
    if (hr1_q >= 5'd24)      hr12 = hr1_q - 5'd24;
    else if (hr1_q >= 5'd12) hr12 = hr1_q - 5'd12;
    else                     hr12 = hr1_q;
    if (hr12 == 5'd0) hr12 = 5'd12;

    if (lower)                value = mn1_q;
    else if (cfg_i.twelve)    value = {1'b0, hr12};
    else                      value = {1'b0, hr1_q};

    // value / 10 by reciprocal, exact for every 6-bit value
    tens_prod = 14'(value) * 14'd205;
    tens      = {1'b0, tens_prod[13:11]};
    ones      = 4'(value - 6'(tens) * 6'd10);
    digit     = right ? ones : tens;

    gc  = right ? 3'(col1_q - 4'(FarCell)) : col1_q[2:0];
    gr  = lower ? 3'(row1_q - 4'(FarCell)) : row1_q[2:0];
    lit = (right || col1_q < 4'(GlyphSide)) && glyph_bit(digit, gr, gc);

    if (!tv1_q)                         kind2_d = (wait_row && wait_col) ? KIND_WAIT : KIND_DARK;
    else if (row1_q == 4'(BarRow) || row1_q == 4'(BarRow + 1)) kind2_d = KIND_BAR;
    else if (lit)                       kind2_d = lower ? KIND_MIN : KIND_HOUR;
    else                                kind2_d = KIND_DARK;

    sec_c = (sec1_q > SEC_MAX) ? SEC_MAX : sec1_q;
    us_c  = (us1_q > US_MAX) ? US_MAX : us1_q;
    t2_d  = 26'(sec_c) * US_PER_SEC + 26'(us_c);
    lo2_d = 26'(col1_q) * US_PER_COL;
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && v_q[0]) begin
      kind2_q <= kind2_d;
      t2_q    <= t2_d;
      lo2_q   <= lo2_d;
    end
  end

  // stage 3: where the time falls against this column's span
  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      kind3_q <= kind2_q;
      diff3_q <= 22'(t2_q - lo2_q);
      if (t2_q <= lo2_q)                    cls3_q <= BAR_NONE;
      else if (t2_q >= lo2_q + US_PER_COL)  cls3_q <= BAR_FULL;
      else                                  cls3_q <= BAR_PART;
    end
  end

  // stage 4: bar shade times covered time
  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      kind4_q <= kind3_q;
      cls4_q  <= cls3_q;
      prod4_q <= 30'(cfg_i.bar_level) * 30'(diff3_q);
    end
  end

  // stage 5: quotient estimate, low by at most one
  logic [40:0] est5;
  assign est5 = 41'(prod4_q[29:4]) * COL_RECIP;

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      kind5_q <= kind4_q;
      cls5_q  <= cls4_q;
      num5_q  <= prod4_q[29:4];
      q05_q   <= est5[39:32];
    end
  end

  // stage 6: quotient correction and shade select
  logic [25:0] rem6;
  logic [7:0]  quot6, shade6_d;
  always_comb begin
    rem6  = num5_q - 26'(q05_q) * COL_DIV;
    quot6 = (rem6 >= COL_DIV) ? q05_q + 8'd1 : q05_q;
    case (kind5_q)
      KIND_WAIT: shade6_d = WAIT_SHADE;
      KIND_HOUR: shade6_d = cfg_i.full;
      KIND_MIN:  shade6_d = cfg_i.min_level;
      KIND_BAR: begin
        case (cls5_q)
          BAR_FULL: shade6_d = cfg_i.bar_level;
          BAR_PART: shade6_d = quot6;
          default:  shade6_d = 8'd0;
        endcase
      end
      default:   shade6_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && v_q[4]) begin
      shade6_q <= shade6_d;
    end
  end

  assign out_valid_o   = v_q[5];
  assign pixel_shade_o = shade6_q;
  assign stat_o        = '{stage_v: v_q};

endmodule

>>> hw/rtl/clock_face_pixel_renderer_unit.sv
// Top level of the clock face pixel renderer: stream ports, register block, datapath.
// Pipeline: six registers lie between an accepted input transaction and its result.
// Throughput: one pixel per cycle while m_axis_tready is high; each stage takes a new
//   transaction as soon as it is empty or its successor moves, so bubbles are squeezed
//   out while the output stalls.
// Reset: asynchronous, active low; empties the pipeline and loads the register defaults
//   (minute level 70 %, bar level 45 %, 24-hour form, full brightness 255).
module clock_face_pixel_renderer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input pixel request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] column, [7:4] row, [12:8] hour, [18:13] minute, [24:19] second,
  // [44:25] microsecond, [47:45] zero
  input  logic [47:0] s_axis_tdata,
  // [0] time_valid
  input  logic        s_axis_tuser,
  // result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_shade
  output logic [7:0]  m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfpr_pkg::*;

  cfg_t  cfg;
  stat_t stat;

  // Register block; written brightness levels are pre-scaled in the product and level
  // registers before a transaction accepted with the write reaches the stage using them.
  cfpr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pixel datapath: field capture, font lookup, bar span compare, bar scaling,
  // reciprocal divide, correction and output register.
  cfpr_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .column_i      (s_axis_tdata[3:0]),
    .row_i         (s_axis_tdata[7:4]),
    .time_valid_i  (s_axis_tuser),
    .hour_i        (s_axis_tdata[12:8]),
    .minute_i      (s_axis_tdata[18:13]),
    .second_i      (s_axis_tdata[24:19]),
    .microsecond_i (s_axis_tdata[44:25]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_shade_o (m_axis_tdata),
    .stat_o        (stat)
  );

  // A ready downstream never holds back the input side.
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output side is ready");

  // An accepted transaction lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> stat.stage_v[0])
    else $error("accepted transaction missing from first stage");

  // A full output register that is taken frees room, so its predecessor can advance.
  a_output_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.stage_v[5] && m_axis_tready && stat.stage_v[4]) |=> stat.stage_v[5])
    else $error("output register lost a waiting result");

endmodule

>>> tb/clock_face_pixel_renderer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the clock face pixel renderer: stream stimulus, APB settings, scoreboard.
module clock_face_pixel_renderer_unit_tb;
  import cfpr_pkg::*;

  // Run length guard, in clock cycles. It sits well above the slowest correct run
  // (about 950 pixels, sender gaps, slow receiver, one long hold-off).
  localparam int unsigned CYCLE_LIMIT  = 300000;
  // Receiver hold-off: starts once this many pixels have gone in, lasts this long.
  localparam int unsigned HOLD_AFTER   = 450;
  localparam int unsigned HOLD_CYCLES  = 250;
  // Pipeline is six deep; settle margin before settings change and at the end.
  localparam int unsigned SETTLE       = 12;
  localparam int unsigned PHASE_PIXELS = 100;
  localparam int unsigned PHASES       = 9;

  // Our own copy of the 7x7 digit font, MSB is the leftmost column.
  localparam bit [6:0] FONT [10][7] = '{
    '{7'h3E, 7'h63, 7'h63, 7'h63, 7'h63, 7'h63, 7'h3E},
    '{7'h18, 7'h38, 7'h18, 7'h18, 7'h18, 7'h18, 7'h3E},
    '{7'h3E, 7'h63, 7'h03, 7'h0E, 7'h38, 7'h60, 7'h7F},
    '{7'h3E, 7'h63, 7'h03, 7'h1E, 7'h03, 7'h63, 7'h3E},
    '{7'h0E, 7'h1E, 7'h36, 7'h66, 7'h7F, 7'h06, 7'h06},
    '{7'h7F, 7'h60, 7'h7E, 7'h03, 7'h03, 7'h63, 7'h3E},
    '{7'h1E, 7'h30, 7'h60, 7'h7E, 7'h63, 7'h63, 7'h3E},
    '{7'h7F, 7'h06, 7'h0C, 7'h18, 7'h18, 7'h18, 7'h18},
    '{7'h3E, 7'h63, 7'h63, 7'h3E, 7'h63, 7'h63, 7'h3E},
    '{7'h3E, 7'h63, 7'h63, 7'h3F, 7'h03, 7'h03, 7'h3E}
  };

  typedef struct {
    logic [3:0]  col;
    logic [3:0]  row;
    logic        time_valid;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] microsecond;
  } pixel_req_t;

  // Scoreboard: mirrors the settings, predicts each pixel's shade on input
  // acceptance and checks results in order.
  class shade_scoreboard;
    logic [6:0] min_pct;
    logic [6:0] bar_pct;
    logic       twelve;
    logic [7:0] full;
    logic [7:0] pending_shades[$];
    int unsigned mismatches;

    function new();
      min_pct    = 7'd70;
      bar_pct    = 7'd45;
      twelve     = 1'b0;
      full       = 8'd255;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_MIN_PCT: min_pct = value[6:0];
        REG_BAR_PCT: bar_pct = value[6:0];
        REG_TWELVE:  twelve  = value[0];
        REG_FULL:    full    = value[7:0];
        default: ;
      endcase
    endfunction

    // percent of full brightness, percent saturating at 100
    function int unsigned level_of(logic [6:0] pct);
      int unsigned p;
      p = 32'((pct > PCT_MAX) ? PCT_MAX : pct);
      return (int'(full) * p) / 100;
    endfunction

    function logic [7:0] shade_of(pixel_req_t req);
      int unsigned x, y, c, r, value, level, digit, s, sec, us;
      longint unsigned t, lo, span;
      logic [7:0] shade;
      x     = 32'(req.col);
      y     = 32'(req.row);
      shade = 8'd0;
      span  = 64'(US_PER_COL);
      if (!req.time_valid) begin
        // waiting pattern: four dashes
        if ((y == 3 || y == FarCell + 3) &&
            ((x >= 1 && x <= 5) || (x >= FarCell + 1 && x <= FarCell + 5)))
          shade = WAIT_SHADE;
      end else if (y == BarRow || y == BarRow + 1) begin
        s = level_of(bar_pct);
        if (s > 0) begin
          sec = 32'((req.second > SEC_MAX) ? SEC_MAX : req.second);
          us  = 32'((req.microsecond > US_MAX) ? US_MAX : req.microsecond);
          t   = 64'(sec) * 64'd1000000 + 64'(us);
          lo  = 64'(x) * span;
          if (t <= lo)
            shade = 8'd0;
          else if (t >= lo + span)
            shade = s[7:0];
          else
            shade = 8'((64'(s) * (t - lo)) / span);
        end
      end else if (x < GlyphSide || x >= FarCell) begin
        c = (x >= FarCell) ? x - FarCell : x;
        r = (y >= FarCell) ? y - FarCell : y;
        if (y >= FarCell) begin
          value = 32'(req.minute);
          level = level_of(min_pct);
        end else begin
          value = 32'(req.hour);
          if (twelve) begin
            value = value % 12;
            if (value == 0) value = 12;
          end
          level = 32'(full);
        end
        digit = (x >= FarCell) ? value % 10 : value / 10;
        if (digit <= 9 && FONT[4'(digit)][3'(r)][3'(GlyphSide - 1 - c)])
          shade = level[7:0];
      end
      return shade;
    endfunction

    function void note_request(pixel_req_t req);
      pending_shades.push_back(shade_of(req));
    endfunction

    function void check_shade(logic [7:0] got);
      logic [7:0] want;
      if (pending_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: shade %0d with nothing outstanding", got);
      end else begin
        want = pending_shades.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel_shade mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  shade_scoreboard sb;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;

  clock_face_pixel_renderer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("clock_face_pixel_renderer_unit_tb failed");
    $finish;
  end

  // Result monitor: values seen at the rising edge are the pre-edge ones, so
  // a transaction is exactly valid && ready as sampled here.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_shade(m_axis_tdata);
  end

  // Receiver: ready pattern rotates through always, half, sparse and three in four.
  // Once, after HOLD_AFTER pixels, it holds off long enough for the pipeline to fill
  // and push back on the input.
  initial begin : receiver
    int unsigned rx_cycle;
    bit          hold_done;
    rx_cycle  = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (!hold_done && requests_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        case ((rx_cycle / 97) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(1, 0) == 0);
          2: m_axis_tready <= ($urandom_range(4, 0) == 0);
          default: m_axis_tready <= ((rx_cycle % 4) != 0);
        endcase
      end
    end
  end

  function automatic pixel_req_t mk_pixel(int col, int row, bit valid, int hour, int minute,
                                          int second, int us);
    pixel_req_t p;
    p.col         = 4'(col);
    p.row         = 4'(row);
    p.time_valid  = valid;
    p.hour        = 5'(hour);
    p.minute      = 6'(minute);
    p.second      = 6'(second);
    p.microsecond = 20'(us);
    return p;
  endfunction

  // Mostly in-range times; a share of out-of-range fields for the saturation
  // and wrap paths. Bar rows are favoured, often at the partly lit column.
  function automatic pixel_req_t random_pixel();
    pixel_req_t      p;
    longint unsigned t;
    p.col         = 4'($urandom_range(15, 0));
    p.row         = 4'($urandom_range(15, 0));
    p.time_valid  = ($urandom_range(9, 0) != 0);
    p.hour        = 5'(($urandom_range(7, 0) == 0) ? $urandom_range(31, 0)
                                                   : $urandom_range(23, 0));
    p.minute      = 6'(($urandom_range(7, 0) == 0) ? $urandom_range(63, 0)
                                                   : $urandom_range(59, 0));
    p.second      = 6'(($urandom_range(7, 0) == 0) ? $urandom_range(63, 0)
                                                   : $urandom_range(59, 0));
    p.microsecond = 20'(($urandom_range(4, 0) == 0) ? $urandom_range('hFFFFF, 0)
                                                    : $urandom_range(999999, 0));
    if ($urandom_range(3, 0) == 0)
      p.row = 4'(BarRow + $urandom_range(1, 0));
    if ((p.row == BarRow || p.row == BarRow + 1) && $urandom_range(1, 0) == 0) begin
      t = 64'((p.second > SEC_MAX) ? SEC_MAX : p.second) * 64'd1000000 +
          64'((p.microsecond > US_MAX) ? US_MAX : p.microsecond);
      p.col = 4'(t / 64'(US_PER_COL));
    end
    return p;
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_pixel(pixel_req_t p);
    s_axis_tdata  <= {3'b000, p.microsecond, p.second, p.minute, p.hour, p.row, p.col};
    s_axis_tuser  <= p.time_valid;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(p);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // APB write: setup, access, then release. Starts on the next falling edge.
  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_shades.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Settings only change with the pipeline empty.
  task automatic apply_settings(int min_pct, int bar_pct, bit twelve, int full);
    idle_cycles(1);
    wait_drained();
    apb_write(REG_MIN_PCT, min_pct);
    apb_write(REG_BAR_PCT, bar_pct);
    apb_write(REG_TWELVE, 32'(twelve));
    apb_write(REG_FULL, full);
  endtask

  // Bursts of random length with random gaps; gap zero runs bursts together.
  task automatic random_phase(int unsigned count);
    int unsigned left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      if (burst > left) burst = left;
      left -= burst;
      repeat (burst) send_pixel(random_pixel());
      idle_cycles(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1));
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed pixels under the reset settings.
    // waiting pattern: dash ends, a gap and an off-row pixel
    send_pixel(mk_pixel(1, 3, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(14, 12, 0, 23, 59, 59, 999999));
    send_pixel(mk_pixel(0, 3, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(7, 3, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(5, 0, 0, 12, 34, 0, 0));
    // hour and minute digits, lit and dark cells, the centre gap
    send_pixel(mk_pixel(1, 0, 1, 23, 0, 0, 0));
    send_pixel(mk_pixel(10, 1, 1, 23, 0, 0, 0));
    send_pixel(mk_pixel(0, 0, 1, 0, 0, 0, 0));
    send_pixel(mk_pixel(9, 9, 1, 0, 59, 0, 0));
    send_pixel(mk_pixel(15, 15, 1, 0, 59, 0, 0));
    send_pixel(mk_pixel(7, 2, 1, 8, 8, 0, 0));
    send_pixel(mk_pixel(8, 12, 1, 8, 8, 0, 0));
    // hour and minute above range shown as their decimal digits
    send_pixel(mk_pixel(12, 4, 1, 31, 0, 0, 0));
    send_pixel(mk_pixel(3, 15, 1, 0, 63, 0, 0));
    // seconds bar: empty, full, half, boundaries, saturating second and microsecond
    send_pixel(mk_pixel(0, 7, 1, 0, 0, 0, 0));
    send_pixel(mk_pixel(0, 8, 1, 0, 0, 3, 750000));
    send_pixel(mk_pixel(0, 7, 1, 0, 0, 1, 875000));
    send_pixel(mk_pixel(4, 7, 1, 0, 0, 15, 0));
    send_pixel(mk_pixel(3, 8, 1, 0, 0, 15, 0));
    send_pixel(mk_pixel(15, 8, 1, 0, 0, 59, 999999));
    send_pixel(mk_pixel(15, 7, 1, 0, 0, 63, 'hFFFFF));

    // 12-hour form: midnight and noon both read 12, afternoon wraps
    apply_settings(70, 45, 1'b1, 255);
    send_pixel(mk_pixel(1, 0, 1, 0, 0, 0, 0));
    send_pixel(mk_pixel(10, 2, 1, 12, 0, 0, 0));
    send_pixel(mk_pixel(10, 2, 1, 13, 0, 0, 0));
    send_pixel(mk_pixel(12, 4, 1, 31, 0, 0, 0));

    // Random phases, each under its own settings; extremes come first:
    // minimum listed level, full bar, bar off, minute level zero, percent
    // above 100, zero and tiny full brightness.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(20, 100, 1'b1, 255);
        1: apply_settings(100, 0, 1'b0, 255);
        2: apply_settings(0, 127, 1'b1, 128);
        3: apply_settings(127, 1, 1'b0, 0);
        4: apply_settings(19, 50, 1'b1, 1);
        5: apply_settings(101, 101, 1'b0, 200);
        default: apply_settings($urandom_range(127, 0), $urandom_range(127, 0),
                                1'($urandom_range(1, 0)), $urandom_range(255, 0));
      endcase
      random_phase(PHASE_PIXELS);
    end

    // Drain and allow a little beyond the pipeline latency for strays.
    idle_cycles(1);
    wait_drained();
    if (sb.mismatches == 0 && sb.pending_shades.size() == 0) begin
      $display("clock_face_pixel_renderer_unit_tb passed");
    end else begin
      $display("clock_face_pixel_renderer_unit_tb failed");
    end
    $finish;
  end

endmodule
